// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, removed when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define EVR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define EVR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) else $error(msg);
`else
`define EVR_ASSERT(lbl, clk, rst_n, prop, msg)
`define EVR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- hw/rtl/evr_pkg.sv -----
// ----------------------------------------------------------------------------
// Event ring log package
// Depth, widths, codes, record layout and pointer helpers.
// ----------------------------------------------------------------------------
package evr_pkg;

    localparam int LOG_DEPTH = 16;
    localparam int PTR_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
    localparam int OFF_W     = 10;
    localparam int ENTRY_W   = 5;
    localparam int TIME_W    = 63;
    localparam int SUM_W     = ((OFF_W > CNT_W) ? OFF_W : CNT_W) + 1;

    localparam logic [TIME_W-1:0] THRESH_RESET = 63'd1577836800;
    localparam logic [31:0]       TIME_OK_FLAG = 32'h0000_0001;
    localparam logic [31:0]       SEQ_START    = 32'd1;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_KIND  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]        kind;
        logic [TIME_W-1:0] stamp;
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic [31:0]       flags;
        logic [31:0]       seq;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic append;
        logic clear;
    } t_ptr_cmd;

    typedef struct packed {
        logic [PTR_W-1:0] wr_slot;
        logic [PTR_W-1:0] rd_slot;
        logic             rd_hit;
        logic [31:0]      seq;
        logic [CNT_W-1:0] count_after;
    } t_ptr_stat;

    // p + o folded once into the ring; valid for p + o < 2 * LOG_DEPTH
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                  input logic [SUM_W-1:0] o);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(p) + o;
        if (sum >= SUM_W'(LOG_DEPTH)) begin
            sum = sum - SUM_W'(LOG_DEPTH);
        end
        return PTR_W'(sum);
    endfunction

endpackage

// ----- hw/rtl/evr_ram.sv -----
// ----------------------------------------------------------------------------
// Record RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module evr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/evr_ptrs.sv -----
// ----------------------------------------------------------------------------
// Ring pointers
// Head, tail, fill count and sequence counter of the record ring.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module evr_ptrs import evr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ptr_cmd         i_cmd,
    input  logic [OFF_W-1:0] i_offset,
    output t_ptr_stat        o_stat
);

    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic [31:0]      r_seq, n_seq;
    logic             full;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(LOG_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full = (r_count == CNT_W'(LOG_DEPTH));

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_seq   = r_seq;
        if (i_cmd.clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
            n_seq   = SEQ_START;
        end else if (i_cmd.append) begin
            n_head = ptr_inc(r_head);
            n_seq  = r_seq + 32'd1;
            if (full) begin
                n_tail = ptr_inc(r_tail);
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_seq   <= SEQ_START;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_seq   <= n_seq;
        end
    end

    always_comb begin
        o_stat.wr_slot     = r_head;
        o_stat.rd_slot     = wrap_add(r_tail, SUM_W'(i_offset));
        o_stat.rd_hit      = SUM_W'(i_offset) < SUM_W'(r_count);
        o_stat.seq         = r_seq;
        o_stat.count_after = n_count;
    end

    `EVR_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(LOG_DEPTH), "fill count over depth")
    `EVR_ASSERT(a_head_tail, i_clk, i_rst_n, r_head == wrap_add(r_tail, SUM_W'(r_count)), "head not tail plus count")
    `EVR_ASSERT_NEXT(a_clear, i_clk, i_rst_n, i_cmd.clear, (r_count == '0) && (r_seq == SEQ_START), "clear did not empty ring")

endmodule

// ----- hw/rtl/overwriting_event_ring_log.sv -----
// ----------------------------------------------------------------------------
// Overwriting event ring log
// Ring of event records in one RAM; append overwrites the oldest when full.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        to log     i_in_valid / o_in_ready   i_req_type .. i_read_offset
//  out       from log   o_out_valid / i_out_ready o_status .. o_out_sequence
//  cfg       to log     i_cfg_valid / o_cfg_ready i_cfg_data (time threshold)
//
//  Append, clear, unused, rejected append and missed read: result registered
//  at the accept edge. A read that hits passes through S_READ: the record
//  RAM has a registered read port and no new item enters meanwhile.
//  Synchronous active-low reset empties the ring; no RAM clearing is needed.
//  o_in_ready drops while a result waits in the output register untaken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module overwriting_event_ring_log import evr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_event_kind,
    input  logic signed [31:0] i_first_value,
    input  logic signed [31:0] i_second_value,
    input  logic [31:0]        i_event_flags,
    input  logic [TIME_W-1:0]  i_now_seconds,
    input  logic [OFF_W-1:0]   i_read_offset,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [ENTRY_W-1:0] o_entry_count,
    output logic [7:0]         o_out_kind,
    output logic [TIME_W-1:0]  o_out_time,
    output logic signed [31:0] o_out_first,
    output logic signed [31:0] o_out_second,
    output logic [31:0]        o_out_flags,
    output logic [31:0]        o_out_sequence,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [TIME_W-1:0]  i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [TIME_W-1:0] r_thresh;
    logic             r_out_valid, n_out_valid;
    t_status          r_status;
    logic [CNT_W-1:0] r_count;
    t_rec             r_rec;

    logic      accept;
    logic      is_append, is_read, is_clear;
    logic      append_ok, read_hit, time_ok;
    t_ptr_cmd  ptr_cmd;
    t_ptr_stat ptr_stat;
    t_rec      wr_rec;
    t_rec      rd_rec;
    t_status   acc_status;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;

    assign is_append = (i_req_type == REQ_APPEND);
    assign is_read   = (i_req_type == REQ_READ);
    assign is_clear  = (i_req_type == REQ_CLEAR);
    assign append_ok = accept && is_append && (i_event_kind != 8'd0);
    assign read_hit  = accept && is_read && ptr_stat.rd_hit;
    assign time_ok   = (i_now_seconds >= r_thresh);

    assign ptr_cmd.append = append_ok;
    assign ptr_cmd.clear  = accept && is_clear;

    evr_ptrs u_ptrs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ptr_cmd),
        .i_offset (i_read_offset),
        .o_stat   (ptr_stat)
    );

    always_comb begin
        wr_rec.kind   = i_event_kind;
        wr_rec.stamp  = time_ok ? i_now_seconds : '0;
        wr_rec.first  = i_first_value;
        wr_rec.second = i_second_value;
        wr_rec.flags  = time_ok ? (i_event_flags | TIME_OK_FLAG) : i_event_flags;
        wr_rec.seq    = ptr_stat.seq;
    end

    evr_ram #(
        .WIDTH (REC_W),
        .DEPTH (LOG_DEPTH),
        .ADDR_W(PTR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (append_ok),
        .i_wr_addr (ptr_stat.wr_slot),
        .i_wr_data (wr_rec),
        .i_rd_en   (read_hit),
        .i_rd_addr (ptr_stat.rd_slot),
        .o_rd_data (rd_rec)
    );

    always_comb begin
        acc_status = ST_OK;
        if (is_append && (i_event_kind == 8'd0)) begin
            acc_status = ST_BAD_KIND;
        end else if (is_read && !ptr_stat.rd_hit) begin
            acc_status = ST_NOT_FOUND;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (read_hit) begin
                    n_state = S_READ;
                end else if (accept) begin
                    n_out_valid = 1'b1;
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thresh    <= THRESH_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_thresh <= i_cfg_data;
            end
        end
    end

    // result payload: status and count at accept, record once the RAM answers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= acc_status;
            r_count  <= ptr_stat.count_after;
            r_rec    <= '0;
        end else if (r_state == S_READ) begin
            r_rec <= rd_rec;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_entry_count  = ENTRY_W'(r_count);
    assign o_out_kind     = r_rec.kind;
    assign o_out_time     = r_rec.stamp;
    assign o_out_first    = r_rec.first;
    assign o_out_second   = r_rec.second;
    assign o_out_flags    = r_rec.flags;
    assign o_out_sequence = r_rec.seq;

    `EVR_ASSERT(a_read_slot_free, i_clk, i_rst_n, (r_state != S_READ) || !r_out_valid, "read data lands on full output")
    `EVR_ASSERT_NEXT(a_read_done, i_clk, i_rst_n, r_state == S_READ, r_out_valid && (r_status == ST_OK), "read item not delivered")

endmodule

// ----- verif/overwriting_event_ring_log_tb.sv -----
// ----------------------------------------------------------------------------
// Overwriting event ring log testbench
// Drives append, read, clear and unused requests with random idle gaps and
// random output stalls, under several time thresholds. A model of the ring
// in the bench predicts each result but the pinned directed rows, and each
// result is checked field by field in order. The run starts with a directed
// table and then random bursts; some fill the ring, wrap it and read it back.
// ----------------------------------------------------------------------------
module overwriting_event_ring_log_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import evr_pkg::*;

    localparam logic [1:0]        REQ_UNUSED  = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
    localparam int                GAP_MAX     = 12;
    localparam int                MAX_SHOWN   = 10;
    localparam int                NUM_PHASES  = 6;
    localparam int                PHASE_ITEMS = 300;
    localparam int                DIR_ROWS    = 21;

    typedef struct {
        logic [1:0]         req;
        logic [7:0]         kind;
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic [31:0]        flags;
        logic [TIME_W-1:0]  now;
        logic [OFF_W-1:0]   offset;
    } t_log_req;

    typedef struct {
        t_status            status;
        logic [ENTRY_W-1:0] count;
        t_rec               rec;
    } t_log_result;

    typedef struct {
        t_log_req rq;
        bit       pinned;
        t_status  status;
        int       count;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_req_type;
    logic [7:0]         i_event_kind;
    logic signed [31:0] i_first_value;
    logic signed [31:0] i_second_value;
    logic [31:0]        i_event_flags;
    logic [TIME_W-1:0]  i_now_seconds;
    logic [OFF_W-1:0]   i_read_offset;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_status;
    logic [ENTRY_W-1:0] o_entry_count;
    logic [7:0]         o_out_kind;
    logic [TIME_W-1:0]  o_out_time;
    logic signed [31:0] o_out_first;
    logic signed [31:0] o_out_second;
    logic [31:0]        o_out_flags;
    logic [31:0]        o_out_sequence;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [TIME_W-1:0]  i_cfg_data;

    t_log_req    cur_req;
    bit          pin_row;
    t_status     pin_status;
    int          pin_count;
    t_log_result expected_q [$];
    int          fail_count;
    int          tx_quiet;
    int          rx_quiet;
    int          out_hold;

    // bench copy of the ring
    t_rec              ring_mem [LOG_DEPTH];
    int                ring_head;
    int                ring_tail;
    int                ring_fill;
    logic [31:0]       next_seq;
    logic [TIME_W-1:0] time_floor;

    assign i_req_type     = cur_req.req;
    assign i_event_kind   = cur_req.kind;
    assign i_first_value  = cur_req.first;
    assign i_second_value = cur_req.second;
    assign i_event_flags  = cur_req.flags;
    assign i_now_seconds  = cur_req.now;
    assign i_read_offset  = cur_req.offset;

    overwriting_event_ring_log u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_event_kind   (i_event_kind),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_event_flags  (i_event_flags),
        .i_now_seconds  (i_now_seconds),
        .i_read_offset  (i_read_offset),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_out_kind     (o_out_kind),
        .o_out_time     (o_out_time),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_out_flags    (o_out_flags),
        .o_out_sequence (o_out_sequence),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // idle cycles before the next item; now and then a run of items with none
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            quiet = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    function automatic t_log_result apply_log_op(input t_log_req rq);
        t_log_result r;
        t_rec        w;
        r.status = ST_OK;
        r.rec    = '0;
        case (rq.req)
            REQ_APPEND: begin
                if (rq.kind == 8'd0) begin
                    r.status = ST_BAD_KIND;
                end else begin
                    w.kind   = rq.kind;
                    w.first  = rq.first;
                    w.second = rq.second;
                    w.seq    = next_seq;
                    if (rq.now >= time_floor) begin
                        w.stamp = rq.now;
                        w.flags = rq.flags | TIME_OK_FLAG;
                    end else begin
                        w.stamp = '0;
                        w.flags = rq.flags;
                    end
                    ring_mem[ring_head] = w;
                    next_seq  = next_seq + 32'd1;
                    ring_head = (ring_head + 1) % LOG_DEPTH;
                    if (ring_fill < LOG_DEPTH) begin
                        ring_fill++;
                    end else begin
                        ring_tail = (ring_tail + 1) % LOG_DEPTH;
                    end
                end
            end
            REQ_READ: begin
                if (int'(rq.offset) >= ring_fill) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.rec = ring_mem[(ring_tail + int'(rq.offset)) % LOG_DEPTH];
                end
            end
            REQ_CLEAR: begin
                ring_head = 0;
                ring_tail = 0;
                ring_fill = 0;
                next_seq  = SEQ_START;
            end
            default: ;
        endcase
        r.count = ENTRY_W'(ring_fill);
        return r;
    endfunction

    // tidy requests carry a non-zero kind and, if the ring is not empty, an offset that hits
    function automatic t_log_req random_request(input logic [1:0] op, input bit tidy);
        t_log_req rq;
        rq.req    = op;
        rq.first  = $urandom;
        rq.second = $urandom;
        rq.flags  = $urandom;
        if (tidy || $urandom_range(0, 1) == 0) begin
            rq.kind = 8'($urandom_range(1, 255));
        end else begin
            rq.kind = 8'd0;
        end
        case ($urandom_range(0, 5))
            0:       rq.now = '0;
            1:       rq.now = TIME_MAX;
            2:       rq.now = time_floor;
            3:       rq.now = time_floor - 1'b1;
            4:       rq.now = time_floor + TIME_W'($urandom_range(0, 1000));
            default: rq.now = TIME_W'({$urandom, $urandom});
        endcase
        if (tidy && ring_fill > 0) begin
            rq.offset = OFF_W'($urandom_range(0, ring_fill - 1));
        end else begin
            case ($urandom_range(0, 2))
                0:       rq.offset = OFF_W'(ring_fill);
                1:       rq.offset = {OFF_W{1'b1}};
                default: rq.offset = OFF_W'($urandom_range(0, 1023));
            endcase
        end
        return rq;
    endfunction

    // called just after a falling edge; returns just after a falling edge, once the request has been accepted
    task automatic send_request(input t_log_req rq, input bit pin, input t_status pst,
                                input int pcnt);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cur_req    = rq;
        pin_row    = pin;
        pin_status = pst;
        pin_count  = pcnt;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        // a hit read holds the block in its read state
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_threshold(input logic [TIME_W-1:0] value);
        i_cfg_data  = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // input and config monitor
    always @(posedge i_clk) begin
        t_log_result r;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            r = apply_log_op(cur_req);
            if (pin_row) begin
                r.status = pin_status;
                r.count  = ENTRY_W'(pin_count);
                r.rec    = '0;
            end
            expected_q.push_back(r);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            time_floor = i_cfg_data;
        end
    end

    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_ready = 1'b0;
            out_hold--;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_log_result e;
        bit          bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_hold = draw_gap(rx_quiet);
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_SHOWN) begin
                    $display("[%0t] result with nothing expected: st=%0d cnt=%0d",
                             $realtime, o_status, o_entry_count);
                end
            end else begin
                e   = expected_q.pop_front();
                bad = 1'b0;
                if (o_status       !== e.status)     bad = 1'b1;
                if (o_entry_count  !== e.count)      bad = 1'b1;
                if (o_out_kind     !== e.rec.kind)   bad = 1'b1;
                if (o_out_time     !== e.rec.stamp)  bad = 1'b1;
                if (o_out_first    !== e.rec.first)  bad = 1'b1;
                if (o_out_second   !== e.rec.second) bad = 1'b1;
                if (o_out_flags    !== e.rec.flags)  bad = 1'b1;
                if (o_out_sequence !== e.rec.seq)    bad = 1'b1;
                if (bad) begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN) begin
                        $display("[%0t] mismatch exp: st=%0d cnt=%0d kind=%h time=%h",
                                 $realtime, e.status, e.count, e.rec.kind, e.rec.stamp);
                        $display("    a=%h b=%h flags=%h seq=%h",
                                 e.rec.first, e.rec.second, e.rec.flags, e.rec.seq);
                        $display("  got: st=%0d cnt=%0d kind=%h time=%h",
                                 o_status, o_entry_count, o_out_kind, o_out_time);
                        $display("    a=%h b=%h flags=%h seq=%h",
                                 o_out_first, o_out_second, o_out_flags, o_out_sequence);
                    end
                end
            end
        end
    end

    initial begin
        t_dir_row          dir_rows [DIR_ROWS];
        logic [TIME_W-1:0] floors [NUM_PHASES];
        t_log_req          rq;
        int                sent;
        int                n;
        int                pick;
        logic [1:0]        op;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_out_ready = 1'b0;
        cur_req     = '{req: REQ_APPEND, kind: 8'd0, first: 32'sd0, second: 32'sd0,
                        flags: 32'd0, now: '0, offset: '0};
        pin_row     = 1'b0;
        pin_status  = ST_OK;
        pin_count   = 0;
        fail_count  = 0;
        tx_quiet    = 0;
        rx_quiet    = 0;
        out_hold    = 0;
        ring_head   = 0;
        ring_tail   = 0;
        ring_fill   = 0;
        next_seq    = SEQ_START;
        time_floor  = THRESH_RESET;

        // req, kind, first, second, flags, now, offset / pinned status, count
        dir_rows = '{
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd0},
              1'b1, ST_NOT_FOUND, 0},
            '{'{REQ_APPEND, 8'h00, 32'sh1, 32'sh2, 32'h3, THRESH_RESET, 10'd0},
              1'b1, ST_BAD_KIND, 0},
            '{'{REQ_UNUSED, 8'h11, 32'sh5, 32'sh6, 32'h7, TIME_MAX, 10'd3},
              1'b1, ST_OK, 0},
            '{'{REQ_APPEND, 8'hff, 32'sh8000_0000, 32'sh7fff_ffff, 32'hffff_ffff,
                63'd0, 10'd0}, 1'b0, ST_OK, 0},
            '{'{REQ_APPEND, 8'h01, 32'sh7fff_ffff, 32'sh8000_0000, 32'h0,
                THRESH_RESET, 10'd0}, 1'b0, ST_OK, 0},
            '{'{REQ_APPEND, 8'h80, 32'sh0, -32'sd1, 32'hffff_fffe, TIME_MAX, 10'd0},
              1'b0, ST_OK, 0},
            '{'{REQ_APPEND, 8'h55, 32'sh1234_5678, 32'shedcb_a987, 32'h5555_5554,
                THRESH_RESET - 63'd1, 10'd0}, 1'b0, ST_OK, 0},
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd0},
              1'b0, ST_OK, 0},
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd1},
              1'b0, ST_OK, 0},
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd2},
              1'b0, ST_OK, 0},
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd3},
              1'b0, ST_OK, 0},
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd4},
              1'b1, ST_NOT_FOUND, 4},
            '{'{REQ_READ, 8'hff, 32'sh0, 32'sh0, 32'h0, TIME_MAX, 10'd1023},
              1'b1, ST_NOT_FOUND, 4},
            '{'{REQ_APPEND, 8'h00, -32'sd1, -32'sd1, 32'hffff_ffff, TIME_MAX, 10'd0},
              1'b1, ST_BAD_KIND, 4},
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd3},
              1'b0, ST_OK, 0},
            '{'{REQ_CLEAR, 8'h22, 32'sh9, 32'sh9, 32'h9, 63'd9, 10'd0},
              1'b1, ST_OK, 0},
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd0},
              1'b1, ST_NOT_FOUND, 0},
            '{'{REQ_APPEND, 8'haa, 32'sh1, 32'sh2, 32'h3, THRESH_RESET + 63'd1, 10'd0},
              1'b0, ST_OK, 0},
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd0},
              1'b0, ST_OK, 0},
            '{'{REQ_UNUSED, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd0},
              1'b1, ST_OK, 1},
            '{'{REQ_READ, 8'h00, 32'sh0, 32'sh0, 32'h0, 63'd0, 10'd0},
              1'b0, ST_OK, 0}
        };

        floors[0] = '0;
        floors[1] = TIME_MAX;
        floors[2] = TIME_W'({$urandom, $urandom});
        floors[3] = THRESH_RESET;
        floors[4] = TIME_W'($urandom);
        floors[5] = TIME_W'(1);

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_request(dir_rows[i].rq, dir_rows[i].pinned, dir_rows[i].status,
                         dir_rows[i].count);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            set_threshold(floors[ph]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 3) begin
                    // fill past the depth so the oldest get overwritten, then read back
                    n = $urandom_range(LOG_DEPTH + 1, LOG_DEPTH + 8);
                    repeat (n) begin
                        send_request(random_request(REQ_APPEND, 1'b1), 1'b0, ST_OK, 0);
                    end
                    sent += n;
                    n = ring_fill;
                    for (int k = 0; k < n; k++) begin
                        rq = random_request(REQ_READ, 1'b1);
                        rq.offset = OFF_W'(k);
                        send_request(rq, 1'b0, ST_OK, 0);
                    end
                    sent += n;
                end else if (pick < 9) begin
                    n = $urandom_range(5, 30);
                    repeat (n) begin
                        pick = $urandom_range(0, 99);
                        if (pick < 50) begin
                            op = REQ_APPEND;
                        end else if (pick < 88) begin
                            op = REQ_READ;
                        end else if (pick < 94) begin
                            op = REQ_CLEAR;
                        end else begin
                            op = REQ_UNUSED;
                        end
                        if ($urandom_range(0, 99) == 0) begin
                            drain_results();
                        end
                        send_request(random_request(op, $urandom_range(0, 9) != 0),
                                     1'b0, ST_OK, 0);
                    end
                    sent += n;
                end else begin
                    send_request(random_request(REQ_CLEAR, 1'b0), 1'b0, ST_OK, 0);
                    n = $urandom_range(1, 8);
                    repeat (n) begin
                        send_request(random_request(REQ_APPEND, 1'b1), 1'b0, ST_OK, 0);
                    end
                    sent += n + 1;
                end
            end
        end

        i_in_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
